// ----- sv/lcsr_pkg.sv -----
package lcsr_pkg;

    // LCG mixing constants
    localparam logic [63:0] MIX_MUL      = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] MIX_ADD      = 64'h1405_7B7E_F767_814F;
    localparam int          DRAW_SHIFT   = 24;
    localparam logic [30:0] SELECT_BOUND = 31'd4;

    // remainder unit: dividend magnitude width and step counter width
    localparam int DVD_W = 64 - DRAW_SHIFT;
    localparam int DCNT_W = $clog2(DVD_W);

    // microprogram counter width
    localparam int PC_W = 6;

    // request commands
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_SELECT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // 32x32 partial product select
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LL,
        MUL_LH,
        MUL_HL
    } t_mul;

    // product accumulator operation
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADDHI,
        ACC_ADDK,
        ACC_ADDSRC
    } t_acc;

    // addend select for ACC_ADDSRC
    typedef enum logic [1:0] {
        ADD_BASE,
        ADD_LAYER,
        ADD_XZ
    } t_asel;

    // work register source
    typedef enum logic [2:0] {
        S_HOLD,
        S_P,
        S_SALT,
        S_WORLD,
        S_LAYER,
        S_COORD
    } t_ssel;

    // seed store write
    typedef enum logic [1:0] {
        W_NONE,
        W_BASE,
        W_LAYER,
        W_COORD
    } t_wr;

    // round counter operation
    typedef enum logic [1:0] {
        C_HOLD,
        C_CLR,
        C_INC
    } t_cnt;

    // sequencer jump condition
    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_CNT_NE_LAST,
        J_CNT_NZ,
        J_DIV_BUSY,
        J_FETCH
    } t_jmp;

    // one microcode word
    typedef struct packed {
        t_mul            mul;
        logic            bsel_k;
        t_acc            acc;
        t_asel           asel;
        t_ssel           ssel;
        t_wr             wr;
        t_cnt            cnt;
        logic            div_init;
        logic            emit;
        t_jmp            jmp;
        logic [PC_W-1:0] tgt;
    } t_cw;

    // datapath controls from the sequencer
    typedef struct packed {
        t_mul  mul;
        logic  bsel_k;
        t_acc  acc;
        t_asel asel;
        t_ssel ssel;
        t_wr   wr;
        logic  xz_z;
        logic  div_init;
        logic  accept;
        logic  emit;
    } t_ctrl;

endpackage

// ----- sv/lcsr_mod.sv -----
module lcsr_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_init,
    input  logic [63:0] i_seed,
    input  logic [30:0] i_bound,
    output logic        o_busy,
    output logic [30:0] o_res
);

    logic                          r_busy;
    logic [lcsr_pkg::DCNT_W-1:0]   r_cnt;
    logic                          r_neg;
    logic [lcsr_pkg::DVD_W-1:0]    r_dvd;
    logic [30:0]                   r_rem;
    logic [30:0]                   r_bound;

    logic [lcsr_pkg::DVD_W-1:0]    t_val;
    logic [lcsr_pkg::DVD_W-1:0]    mag;
    logic [31:0]                   rem_sh;
    logic [31:0]                   rem_sub;
    logic                          fits;

    // shifted seed and its magnitude
    assign t_val = i_seed[63:lcsr_pkg::DRAW_SHIFT];
    assign mag   = i_seed[63] ? (lcsr_pkg::DVD_W'(0) - t_val) : t_val;

    // one restoring step
    assign rem_sh  = {r_rem, r_dvd[lcsr_pkg::DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_bound};
    assign fits    = rem_sh >= {1'b0, r_bound};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_init) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == lcsr_pkg::DCNT_W'(lcsr_pkg::DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_neg   <= i_seed[63];
            r_dvd   <= mag;
            r_rem   <= '0;
            r_bound <= i_bound;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[lcsr_pkg::DVD_W-2:0], 1'b0};
            r_rem <= fits ? rem_sub[30:0] : rem_sh[30:0];
        end
    end

    // floor-mod fixup for a negative dividend
    assign o_res  = (r_neg && (r_rem != '0)) ? (r_bound - r_rem) : r_rem;
    assign o_busy = r_busy;

endmodule

// ----- sv/lcsr_dp.sv -----
module lcsr_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcsr_pkg::t_ctrl       i_ctrl,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic [1:0]            i_cmd,
    input  logic signed [31:0]    i_coord_x,
    input  logic signed [31:0]    i_coord_z,
    input  logic [30:0]           i_limit,
    input  logic signed [31:0]    i_pick_a,
    input  logic signed [31:0]    i_pick_b,
    input  logic signed [31:0]    i_pick_c,
    input  logic signed [31:0]    i_pick_d,
    input  logic [30:0]           i_div_res,
    output logic [63:0]           o_coord,
    output logic [30:0]           o_bound,
    output logic signed [31:0]    o_value,
    output logic                  o_bad_limit
);

    localparam logic REG_SALT = 1'b0;

    logic [63:0]        r_salt;
    logic [63:0]        r_world;
    logic [63:0]        r_base;
    logic [63:0]        r_layer;
    logic [63:0]        r_coord;
    logic [63:0]        r_s;
    logic [63:0]        r_p;
    logic [63:0]        r_m;
    lcsr_pkg::t_cmd     r_cmd;
    logic [31:0]        r_x;
    logic [31:0]        r_z;
    logic [30:0]        r_limit;
    logic [31:0]        r_pick_a;
    logic [31:0]        r_pick_b;
    logic [31:0]        r_pick_c;
    logic [31:0]        r_pick_d;

    logic [63:0]        n_p;
    logic [63:0]        b_word;
    logic [31:0]        a32;
    logic [31:0]        b32;
    logic [63:0]        addend;
    logic [31:0]        pick;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt  <= '0;
            r_world <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SALT) begin
                r_salt <= i_cfg_data;
            end else begin
                r_world <= i_cfg_data;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd    <= lcsr_pkg::t_cmd'(i_cmd);
            r_x      <= i_coord_x;
            r_z      <= i_coord_z;
            r_limit  <= i_limit;
            r_pick_a <= i_pick_a;
            r_pick_b <= i_pick_b;
            r_pick_c <= i_pick_c;
            r_pick_d <= i_pick_d;
        end
    end

    // partial product operands
    assign b_word = i_ctrl.bsel_k ? lcsr_pkg::MIX_MUL : r_s;
    assign a32 = (i_ctrl.mul == lcsr_pkg::MUL_HL) ? r_s[63:32] : r_s[31:0];
    assign b32 = (i_ctrl.mul == lcsr_pkg::MUL_LH) ? b_word[63:32] : b_word[31:0];

    // 32x32 multiplier, registered product
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul != lcsr_pkg::MUL_NONE) begin
            r_m <= {32'b0, a32} * {32'b0, b32};
        end
    end

    // addend select
    always_comb begin
        unique case (i_ctrl.asel)
            lcsr_pkg::ADD_BASE:  addend = r_base;
            lcsr_pkg::ADD_LAYER: addend = r_layer;
            lcsr_pkg::ADD_XZ:    addend = i_ctrl.xz_z ? {{32{r_z[31]}}, r_z}
                                                      : {{32{r_x[31]}}, r_x};
            default:             addend = r_base;
        endcase
    end

    // product accumulator
    always_comb begin
        unique case (i_ctrl.acc)
            lcsr_pkg::ACC_LOAD:   n_p = r_m;
            lcsr_pkg::ACC_ADDHI:  n_p = r_p + {r_m[31:0], 32'b0};
            lcsr_pkg::ACC_ADDK:   n_p = r_p + lcsr_pkg::MIX_ADD;
            lcsr_pkg::ACC_ADDSRC: n_p = r_p + addend;
            default:              n_p = r_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    // work register
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.ssel)
            lcsr_pkg::S_P:     r_s <= r_p;
            lcsr_pkg::S_SALT:  r_s <= r_salt;
            lcsr_pkg::S_WORLD: r_s <= r_world;
            lcsr_pkg::S_LAYER: r_s <= r_layer;
            lcsr_pkg::S_COORD: r_s <= r_coord;
            default:           r_s <= r_s;
        endcase
    end

    // seed stores
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr == lcsr_pkg::W_BASE) begin
            r_base <= r_p;
        end
        if (i_ctrl.wr == lcsr_pkg::W_LAYER) begin
            r_layer <= r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
        end else if (i_ctrl.wr == lcsr_pkg::W_COORD) begin
            r_coord <= r_p;
        end
    end

    // result forming
    always_comb begin
        unique case (i_div_res[1:0])
            2'd0:    pick = r_pick_a;
            2'd1:    pick = r_pick_b;
            2'd2:    pick = r_pick_c;
            default: pick = r_pick_d;
        endcase
    end

    assign o_coord     = r_coord;
    assign o_bound     = (r_cmd == lcsr_pkg::CMD_SELECT) ? lcsr_pkg::SELECT_BOUND : r_limit;
    assign o_bad_limit = (r_cmd != lcsr_pkg::CMD_SELECT) && (r_limit == '0);
    assign o_value     = (r_cmd == lcsr_pkg::CMD_SELECT) ? pick
                       : (o_bad_limit ? 32'sd0 : {1'b0, i_div_res});

endmodule

// ----- sv/lcsr_seq.sv -----
module lcsr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_valid,
    input  logic [1:0]      i_cmd,
    input  logic            i_div_busy,
    input  logic            i_out_block,
    output logic            o_ready,
    output lcsr_pkg::t_ctrl o_ctrl
);

    localparam int PW = lcsr_pkg::PC_W;
    localparam int BODY_LEN = 10;

    // microprogram layout
    localparam logic [PW-1:0] ADDR_FETCH     = PW'(0);
    localparam logic [PW-1:0] ADDR_DERIVE    = PW'(1);
    localparam logic [PW-1:0] ADDR_SALT_MIX  = PW'(2);
    localparam logic [PW-1:0] ADDR_BASE_WR   = ADDR_SALT_MIX + PW'(BODY_LEN);
    localparam logic [PW-1:0] ADDR_LAYER_MIX = ADDR_BASE_WR + PW'(1);
    localparam logic [PW-1:0] ADDR_LAYER_ADD = ADDR_LAYER_MIX + PW'(BODY_LEN);
    localparam logic [PW-1:0] ADDR_LAYER_WR  = ADDR_LAYER_ADD + PW'(1);
    localparam logic [PW-1:0] ADDR_LAYER_END = ADDR_LAYER_WR + PW'(1);
    localparam logic [PW-1:0] ADDR_START     = ADDR_LAYER_END + PW'(1);
    localparam logic [PW-1:0] ADDR_COORD_MIX = ADDR_START + PW'(1);
    localparam logic [PW-1:0] ADDR_COORD_ADD = ADDR_COORD_MIX + PW'(BODY_LEN);
    localparam logic [PW-1:0] ADDR_COORD_WR  = ADDR_COORD_ADD + PW'(1);
    localparam logic [PW-1:0] ADDR_COORD_END = ADDR_COORD_WR + PW'(1);
    localparam logic [PW-1:0] ADDR_DRAW      = ADDR_COORD_END + PW'(1);
    localparam logic [PW-1:0] ADDR_ADV_MIX   = ADDR_DRAW + PW'(1);
    localparam logic [PW-1:0] ADDR_ADV_ADD   = ADDR_ADV_MIX + PW'(BODY_LEN);
    localparam logic [PW-1:0] ADDR_ADV_WAIT  = ADDR_ADV_ADD + PW'(1);
    localparam logic [PW-1:0] ADDR_EMIT      = ADDR_ADV_WAIT + PW'(1);

    localparam logic [1:0] LAYER_ROUNDS = 2'd3;

    // one mix round s*s*MUL + ADD, left in the accumulator
    function automatic lcsr_pkg::t_cw f_body(input logic [3:0] k, input lcsr_pkg::t_cw base);
        lcsr_pkg::t_cw w;
        w = base;
        unique case (k)
            4'd0: w.mul = lcsr_pkg::MUL_LL;
            4'd1: begin
                w.mul = lcsr_pkg::MUL_LH;
                w.acc = lcsr_pkg::ACC_LOAD;
            end
            4'd2: begin
                w.mul = lcsr_pkg::MUL_HL;
                w.acc = lcsr_pkg::ACC_ADDHI;
            end
            4'd3: w.acc = lcsr_pkg::ACC_ADDHI;
            4'd4: w.ssel = lcsr_pkg::S_P;
            4'd5: begin
                w.mul    = lcsr_pkg::MUL_LL;
                w.bsel_k = 1'b1;
            end
            4'd6: begin
                w.mul    = lcsr_pkg::MUL_LH;
                w.bsel_k = 1'b1;
                w.acc    = lcsr_pkg::ACC_LOAD;
            end
            4'd7: begin
                w.mul    = lcsr_pkg::MUL_HL;
                w.bsel_k = 1'b1;
                w.acc    = lcsr_pkg::ACC_ADDHI;
            end
            4'd8: w.acc = lcsr_pkg::ACC_ADDHI;
            4'd9: w.acc = lcsr_pkg::ACC_ADDK;
            default: ;
        endcase
        return w;
    endfunction

    // control store
    function automatic lcsr_pkg::t_cw f_rom(input logic [PW-1:0] a);
        lcsr_pkg::t_cw w;
        w = '{mul: lcsr_pkg::MUL_NONE, bsel_k: 1'b0, acc: lcsr_pkg::ACC_HOLD,
              asel: lcsr_pkg::ADD_BASE, ssel: lcsr_pkg::S_HOLD, wr: lcsr_pkg::W_NONE,
              cnt: lcsr_pkg::C_HOLD, div_init: 1'b0, emit: 1'b0,
              jmp: lcsr_pkg::J_NEXT, tgt: ADDR_FETCH};
        if (a >= ADDR_SALT_MIX && a < ADDR_BASE_WR) begin
            w = f_body(4'(a - ADDR_SALT_MIX), w);
        end
        if (a >= ADDR_LAYER_MIX && a < ADDR_LAYER_ADD) begin
            w = f_body(4'(a - ADDR_LAYER_MIX), w);
        end
        if (a >= ADDR_COORD_MIX && a < ADDR_COORD_ADD) begin
            w = f_body(4'(a - ADDR_COORD_MIX), w);
        end
        if (a >= ADDR_ADV_MIX && a < ADDR_ADV_ADD) begin
            w = f_body(4'(a - ADDR_ADV_MIX), w);
        end
        unique case (a)
            ADDR_FETCH: w.jmp = lcsr_pkg::J_FETCH;
            // base seed from the salt, then world seed rounds
            ADDR_DERIVE: begin
                w.ssel = lcsr_pkg::S_SALT;
                w.cnt  = lcsr_pkg::C_CLR;
            end
            ADDR_BASE_WR: begin
                w.wr   = lcsr_pkg::W_BASE;
                w.ssel = lcsr_pkg::S_WORLD;
            end
            ADDR_LAYER_ADD: begin
                w.acc  = lcsr_pkg::ACC_ADDSRC;
                w.asel = lcsr_pkg::ADD_BASE;
                w.cnt  = lcsr_pkg::C_INC;
            end
            ADDR_LAYER_WR: begin
                w.ssel = lcsr_pkg::S_P;
                w.wr   = lcsr_pkg::W_LAYER;
                w.jmp  = lcsr_pkg::J_CNT_NE_LAST;
                w.tgt  = ADDR_LAYER_MIX;
            end
            ADDR_LAYER_END: w.jmp = lcsr_pkg::J_ALWAYS;
            // coordinate seed: four rounds adding x, z, x, z
            ADDR_START: begin
                w.ssel = lcsr_pkg::S_LAYER;
                w.cnt  = lcsr_pkg::C_CLR;
            end
            ADDR_COORD_ADD: begin
                w.acc  = lcsr_pkg::ACC_ADDSRC;
                w.asel = lcsr_pkg::ADD_XZ;
                w.cnt  = lcsr_pkg::C_INC;
            end
            ADDR_COORD_WR: begin
                w.ssel = lcsr_pkg::S_P;
                w.wr   = lcsr_pkg::W_COORD;
                w.jmp  = lcsr_pkg::J_CNT_NZ;
                w.tgt  = ADDR_COORD_MIX;
            end
            ADDR_COORD_END: w.jmp = lcsr_pkg::J_ALWAYS;
            // draw: remainder runs while the seed advances
            ADDR_DRAW: begin
                w.ssel     = lcsr_pkg::S_COORD;
                w.div_init = 1'b1;
            end
            ADDR_ADV_ADD: begin
                w.acc  = lcsr_pkg::ACC_ADDSRC;
                w.asel = lcsr_pkg::ADD_LAYER;
            end
            ADDR_ADV_WAIT: begin
                w.wr  = lcsr_pkg::W_COORD;
                w.jmp = lcsr_pkg::J_DIV_BUSY;
                w.tgt = ADDR_ADV_WAIT;
            end
            ADDR_EMIT: begin
                w.emit = 1'b1;
                w.jmp  = lcsr_pkg::J_ALWAYS;
            end
            default: ;
        endcase
        return w;
    endfunction

    logic [PW-1:0]  r_pc;
    logic [1:0]     r_cnt;
    logic           r_derive_req;
    logic [PW-1:0]  n_pc;
    logic [1:0]     n_cnt;
    logic           n_derive_req;
    lcsr_pkg::t_cw  cw;
    logic           stall;
    logic           accept;

    assign cw      = f_rom(r_pc);
    assign o_ready = (cw.jmp == lcsr_pkg::J_FETCH) && !r_derive_req;
    assign accept  = o_ready && i_valid;
    assign stall   = cw.emit && i_out_block;

    // next step and round counter
    always_comb begin
        n_pc         = r_pc + 1'b1;
        n_derive_req = r_derive_req | i_cfg_we;
        unique case (cw.jmp)
            lcsr_pkg::J_ALWAYS:      n_pc = cw.tgt;
            lcsr_pkg::J_CNT_NE_LAST: if (r_cnt != LAYER_ROUNDS) n_pc = cw.tgt;
            lcsr_pkg::J_CNT_NZ:      if (r_cnt != '0) n_pc = cw.tgt;
            lcsr_pkg::J_DIV_BUSY:    if (i_div_busy) n_pc = cw.tgt;
            lcsr_pkg::J_FETCH: begin
                n_pc = r_pc;
                if (r_derive_req) begin
                    n_pc         = ADDR_DERIVE;
                    n_derive_req = i_cfg_we;
                end else if (accept) begin
                    unique case (lcsr_pkg::t_cmd'(i_cmd)) inside
                        lcsr_pkg::CMD_START:                       n_pc = ADDR_START;
                        lcsr_pkg::CMD_DRAW, lcsr_pkg::CMD_SELECT:  n_pc = ADDR_DRAW;
                        default:                                   n_pc = ADDR_FETCH;
                    endcase
                end
            end
            default: ;
        endcase
        if (stall) begin
            n_pc = r_pc;
        end

        unique case (cw.cnt)
            lcsr_pkg::C_CLR: n_cnt = '0;
            lcsr_pkg::C_INC: n_cnt = r_cnt + 1'b1;
            default:         n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= ADDR_FETCH;
            r_cnt        <= '0;
            r_derive_req <= 1'b1;
        end else begin
            r_pc         <= n_pc;
            r_cnt        <= n_cnt;
            r_derive_req <= n_derive_req;
        end
    end

    // datapath controls
    always_comb begin
        o_ctrl.mul      = cw.mul;
        o_ctrl.bsel_k   = cw.bsel_k;
        o_ctrl.acc      = cw.acc;
        o_ctrl.asel     = cw.asel;
        o_ctrl.ssel     = cw.ssel;
        o_ctrl.wr       = cw.wr;
        o_ctrl.xz_z     = r_cnt[0];
        o_ctrl.div_init = cw.div_init;
        o_ctrl.accept   = accept;
        o_ctrl.emit     = cw.emit && !stall;
    end

endmodule

// ----- sv/layered_coordinate_seed_random.sv -----
// Start request: the next request is taken once the coordinate seed is written
// (four mix rounds of 12 steps each on one shared 32x32 multiplier).
// Draw/select: the result is registered after the 40-step bit-serial remainder
// unit is done, and the next request is taken after that; the seed advance overlaps it.
// A result still waiting in the output register holds the sequencer at its emit step.
// Reset (sync, active low) and every config write rerun the layer seed
// derivation, during which no request is taken.
module layered_coordinate_seed_random (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_z,
    input  logic [30:0]        i_limit,
    input  logic signed [31:0] i_pick_a,
    input  logic signed [31:0] i_pick_b,
    input  logic signed [31:0] i_pick_c,
    input  logic signed [31:0] i_pick_d,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic               o_bad_limit
);

    lcsr_pkg::t_ctrl    ctrl;
    logic               div_busy;
    logic [30:0]        div_res;
    logic [63:0]        coord;
    logic [30:0]        bound;
    logic signed [31:0] res_value;
    logic               res_bad;
    logic               out_block;

    logic               r_out_valid;
    logic signed [31:0] r_value;
    logic               r_bad;

    assign out_block = r_out_valid && !i_ready;

    lcsr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_div_busy  (div_busy),
        .i_out_block (out_block),
        .o_ready     (o_ready),
        .o_ctrl      (ctrl)
    );

    lcsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_coord_x   (i_coord_x),
        .i_coord_z   (i_coord_z),
        .i_limit     (i_limit),
        .i_pick_a    (i_pick_a),
        .i_pick_b    (i_pick_b),
        .i_pick_c    (i_pick_c),
        .i_pick_d    (i_pick_d),
        .i_div_res   (div_res),
        .o_coord     (coord),
        .o_bound     (bound),
        .o_value     (res_value),
        .o_bad_limit (res_bad)
    );

    lcsr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (ctrl.div_init),
        .i_seed  (coord),
        .i_bound (bound),
        .o_busy  (div_busy),
        .o_res   (div_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_value <= res_value;
            r_bad   <= res_bad;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_value;
    assign o_bad_limit = r_bad;

endmodule
